/* hdl/r10s_pkg.sv */
`timescale 1ns / 1ps
// Package: shared widths, defaults and divider interface types for the RAID-10 splitter.
package r10s_pkg;

   localparam int OFF_W    = 40;  // volume / device byte offset
   localparam int LEN_W    = 24;  // request and command length
   localparam int STRIPE_W = 5;   // primary device index
   localparam int CNT_W    = 6;   // stripe count register, mirror index
   localparam int DIVD_W   = OFF_W + 1;  // dividend: request end needs one extra bit
   localparam int DIVR_W   = 17;  // divisor: block size up to 65536

   localparam int DEF_MAX_STRIPES = 32;
   localparam int DEF_BLOCK_BYTES = 4096;

   localparam logic [CNT_W-1:0] CSR_RESET = CNT_W'(3);

   typedef struct packed {
      logic              go;
      logic [DIVD_W-1:0] dividend;
      logic [DIVR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIVD_W-1:0] quotient;
      logic [DIVR_W-1:0] remainder;
   } div_rsp_type;

endpackage

/* hdl/r10s_divider.sv */
`timescale 1ns / 1ps
// Iterative restoring divider, two quotient bits per cycle.
module r10s_divider (
   input  logic                    clock,
   input  logic                    reset,
   input  r10s_pkg::div_req_type   div_req,
   output r10s_pkg::div_rsp_type   div_rsp
);

   localparam int ITER = (r10s_pkg::DIVD_W + 1) / 2;
   localparam int QW   = 2 * ITER;
   localparam int CW   = $clog2(ITER + 1);
   localparam int RW   = r10s_pkg::DIVR_W;

   logic [QW-1:0] quo_ff, quo_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [RW-1:0] dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;

   logic [RW:0]   t1, t2;
   logic          ge1, ge2;
   logic [RW-1:0] r1, r2;

   always_comb begin
      t1  = {rem_ff, quo_ff[QW-1]};
      ge1 = t1 >= {1'b0, dvs_ff};
      r1  = ge1 ? RW'(t1 - {1'b0, dvs_ff}) : t1[RW-1:0];
      t2  = {r1, quo_ff[QW-2]};
      ge2 = t2 >= {1'b0, dvs_ff};
      r2  = ge2 ? RW'(t2 - {1'b0, dvs_ff}) : t2[RW-1:0];
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (div_req.go) begin
         quo_in = QW'(div_req.dividend);
         rem_in = '0;
         dvs_in = div_req.divisor;
         cnt_in = CW'(ITER);
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[QW-3:0], ge1, ge2};
         rem_in = r2;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff[r10s_pkg::DIVD_W-1:0];
   assign div_rsp.remainder = rem_ff;

endmodule

/* hdl/raid10_stripe_mirror_splitter_top.sv */
`timescale 1ns / 1ps
// Top level: RAID-10 request splitter, one merged command per touched stripe.
// Sequence: accept, four divisions on the shared divider (offset and end by block size,
//   then both block numbers by stripe count), a setup state, then per stripe a calc
//   state (untouched) or calc and emit states (touched, one strobe).
// Throughput: one request per pass; busy is high for the whole pass and the next request is
//   taken at the edge that ends the final strobe. Zero length requests are dropped on accept.
// Reset (synchronous, active high): sequencer idle, no strobe, stripe count back to 3.
module raid10_stripe_mirror_splitter_top #(
   parameter int MAX_STRIPES = r10s_pkg::DEF_MAX_STRIPES,
   parameter int BLOCK_BYTES = r10s_pkg::DEF_BLOCK_BYTES
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_wr_en,
   input  logic [r10s_pkg::CNT_W-1:0]        csr_wr_data,
   // request
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_cmd,
   input  logic [r10s_pkg::OFF_W-1:0]        req_request_offset,
   input  logic [r10s_pkg::LEN_W-1:0]        req_request_length,
   // response
   output logic                              rsp_valid,
   output logic                              rsp_is_write,
   output logic [r10s_pkg::STRIPE_W-1:0]     rsp_primary_target,
   output logic [r10s_pkg::CNT_W-1:0]        rsp_mirror_target,
   output logic [r10s_pkg::OFF_W-1:0]        rsp_device_offset,
   output logic [r10s_pkg::LEN_W-1:0]        rsp_command_length,
   output logic [r10s_pkg::LEN_W-1:0]        rsp_host_offset,
   output logic                              rsp_last
);

   localparam int OW = r10s_pkg::OFF_W;
   localparam int LW = r10s_pkg::LEN_W;
   localparam int SW = r10s_pkg::STRIPE_W;
   localparam int CW = r10s_pkg::CNT_W;
   localparam int DW = r10s_pkg::DIVD_W;
   localparam int RW = r10s_pkg::DIVR_W;
   localparam int QW = LW + 2;  // device block span q1 - q0 always fits here

   localparam logic [RW-1:0] BLK  = RW'(BLOCK_BYTES);
   localparam logic [CW-1:0] MAXS = CW'(MAX_STRIPES);

   // sequencer
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIV_B0 = 3'd1;  // offset / block
   localparam logic [2:0] ST_DIV_B1 = 3'd2;  // end / block
   localparam logic [2:0] ST_DIV_Q0 = 3'd3;  // first block / stripes
   localparam logic [2:0] ST_DIV_Q1 = 3'd4;  // last block / stripes
   localparam logic [2:0] ST_PREP   = 3'd5;
   localparam logic [2:0] ST_CALC   = 3'd6;
   localparam logic [2:0] ST_EMIT   = 3'd7;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] csr_ff;

   // request context
   logic          cmd_ff, cmd_in;
   logic [DW-1:0] end_ff, end_in;
   logic [CW-1:0] n_ff, n_in;

   // division results
   logic [DW-1:0] b0_ff, b0_in, b1_ff, b1_in;
   logic [DW-1:0] q0_ff, q0_in, q1_ff, q1_in;
   logic [RW-1:0] o0_ff, o0_in, e1_ff, e1_in;
   logic [SW-1:0] r0_ff, r0_in, r1_ff, r1_in;

   // per-request setup
   logic [OW-1:0] base_ff, base_in;   // q0 * block
   logic [QW-1:0] dq_ff, dq_in;
   logic [SW-1:0] last_s_ff, last_s_in;

   // per-stripe
   logic [SW-1:0] s_ff, s_in;
   logic [LW-1:0] m_ff, m_in;
   logic [LW-1:0] jb_ff, jb_in;
   logic          lt_ff, lt_in, eq0_ff, eq0_in, eq1_ff, eq1_in;

   // divider request
   logic          div_go_ff, div_go_in;
   logic [DW-1:0] div_dvd_ff, div_dvd_in;
   logic [RW-1:0] div_dvs_ff, div_dvs_in;

   // response registers
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_is_write_ff, rsp_is_write_in;
   logic [SW-1:0] rsp_primary_ff, rsp_primary_in;
   logic [CW-1:0] rsp_mirror_ff, rsp_mirror_in;
   logic [OW-1:0] rsp_devoff_ff, rsp_devoff_in;
   logic [LW-1:0] rsp_len_ff, rsp_len_in;
   logic [LW-1:0] rsp_host_ff, rsp_host_in;
   logic          rsp_last_ff, rsp_last_in;

   r10s_pkg::div_req_type div_req;
   r10s_pkg::div_rsp_type div_rsp;

   assign div_req.go       = div_go_ff;
   assign div_req.dividend = div_dvd_ff;
   assign div_req.divisor  = div_dvs_ff;

   r10s_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // combinational helpers
   logic          accept;
   logic [CW-1:0] eff_n;
   logic          c_lt, c_gt;
   logic [1:0]    c_need;
   logic [CW-1:0] c_j;
   logic          c_touched;
   logic [LW-1:0] e_prod, e_cut0, e_cut1;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      if (csr_ff == '0)
         eff_n = CW'(1);
      else if (csr_ff > MAXS)
         eff_n = MAXS;
      else
         eff_n = csr_ff;
   end

   // stripe s covers device blocks q0+(s<r0) .. q1-(s>r1)
   always_comb begin
      c_lt      = s_ff < r0_ff;
      c_gt      = s_ff > r1_ff;
      c_need    = {1'b0, c_lt} + {1'b0, c_gt};
      c_touched = dq_ff >= QW'(c_need);
      // blocks between the request start and this stripe's first piece
      c_j       = c_lt ? CW'({1'b0, s_ff} + n_ff - {1'b0, r0_ff})
                       : CW'({1'b0, s_ff} - {1'b0, r0_ff});
   end

   always_comb begin
      e_prod = m_ff * LW'(BLK);
      e_cut0 = eq0_ff ? LW'(o0_ff) : '0;                  // head of first block
      e_cut1 = eq1_ff ? LW'(BLK - RW'(1) - e1_ff) : '0;   // tail of last block
   end

   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      end_in          = end_ff;
      n_in            = n_ff;
      b0_in           = b0_ff;
      b1_in           = b1_ff;
      q0_in           = q0_ff;
      q1_in           = q1_ff;
      o0_in           = o0_ff;
      e1_in           = e1_ff;
      r0_in           = r0_ff;
      r1_in           = r1_ff;
      base_in         = base_ff;
      dq_in           = dq_ff;
      last_s_in       = last_s_ff;
      s_in            = s_ff;
      m_in            = m_ff;
      jb_in           = jb_ff;
      lt_in           = lt_ff;
      eq0_in          = eq0_ff;
      eq1_in          = eq1_ff;
      div_go_in       = 1'b0;
      div_dvd_in      = div_dvd_ff;
      div_dvs_in      = div_dvs_ff;
      rsp_valid_in    = 1'b0;
      rsp_is_write_in = rsp_is_write_ff;
      rsp_primary_in  = rsp_primary_ff;
      rsp_mirror_in   = rsp_mirror_ff;
      rsp_devoff_in   = rsp_devoff_ff;
      rsp_len_in      = rsp_len_ff;
      rsp_host_in     = rsp_host_ff;
      rsp_last_in     = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_request_length != '0)) begin
               cmd_in     = req_cmd;
               end_in     = DW'(req_request_offset) + DW'(req_request_length) - DW'(1);
               n_in       = eff_n;
               div_go_in  = 1'b1;
               div_dvd_in = DW'(req_request_offset);
               div_dvs_in = BLK;
               state_in   = ST_DIV_B0;
            end
         end
         ST_DIV_B0: begin
            if (div_rsp.done) begin
               b0_in      = div_rsp.quotient;
               o0_in      = div_rsp.remainder;
               div_go_in  = 1'b1;
               div_dvd_in = end_ff;
               state_in   = ST_DIV_B1;
            end
         end
         ST_DIV_B1: begin
            if (div_rsp.done) begin
               b1_in      = div_rsp.quotient;
               e1_in      = div_rsp.remainder;
               div_go_in  = 1'b1;
               div_dvd_in = b0_ff;
               div_dvs_in = RW'(n_ff);
               state_in   = ST_DIV_Q0;
            end
         end
         ST_DIV_Q0: begin
            if (div_rsp.done) begin
               q0_in      = div_rsp.quotient;
               r0_in      = div_rsp.remainder[SW-1:0];
               div_go_in  = 1'b1;
               div_dvd_in = b1_ff;
               state_in   = ST_DIV_Q1;
            end
         end
         ST_DIV_Q1: begin
            if (div_rsp.done) begin
               q1_in    = div_rsp.quotient;
               r1_in    = div_rsp.remainder[SW-1:0];
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            base_in = q0_ff[OW-1:0] * OW'(BLK);
            dq_in   = QW'(q1_ff - q0_ff);
            // more than one row touched: the top stripe is always hit and closes
            last_s_in = (q1_ff != q0_ff) ? SW'(n_ff - CW'(1)) : r1_ff;
            s_in      = '0;
            state_in  = ST_CALC;
         end
         ST_CALC: begin
            m_in   = LW'(dq_ff + QW'(1) - QW'(c_need));
            jb_in  = LW'(c_j) * LW'(BLK);
            lt_in  = c_lt;
            eq0_in = (s_ff == r0_ff);
            eq1_in = (s_ff == r1_ff);
            if (c_touched)
               state_in = ST_EMIT;
            else
               s_in = s_ff + SW'(1);
         end
         ST_EMIT: begin
            rsp_valid_in    = 1'b1;
            rsp_is_write_in = cmd_ff;
            rsp_primary_in  = s_ff;
            rsp_mirror_in   = CW'({1'b0, s_ff} + n_ff);
            rsp_devoff_in   = base_ff + (lt_ff ? OW'(BLK) : '0) + (eq0_ff ? OW'(o0_ff) : '0);
            rsp_len_in      = e_prod - e_cut0 - e_cut1;
            rsp_host_in     = eq0_ff ? '0 : (jb_ff - LW'(o0_ff));
            rsp_last_in     = (s_ff == last_s_ff);
            if (s_ff == last_s_ff) begin
               state_in = ST_IDLE;
            end else begin
               s_in     = s_ff + SW'(1);
               state_in = ST_CALC;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         csr_ff       <= r10s_pkg::CSR_RESET;
         div_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_go_ff    <= div_go_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en)
            csr_ff <= csr_wr_data;
      end
      cmd_ff          <= cmd_in;
      end_ff          <= end_in;
      n_ff            <= n_in;
      b0_ff           <= b0_in;
      b1_ff           <= b1_in;
      q0_ff           <= q0_in;
      q1_ff           <= q1_in;
      o0_ff           <= o0_in;
      e1_ff           <= e1_in;
      r0_ff           <= r0_in;
      r1_ff           <= r1_in;
      base_ff         <= base_in;
      dq_ff           <= dq_in;
      last_s_ff       <= last_s_in;
      s_ff            <= s_in;
      m_ff            <= m_in;
      jb_ff           <= jb_in;
      lt_ff           <= lt_in;
      eq0_ff          <= eq0_in;
      eq1_ff          <= eq1_in;
      div_dvd_ff      <= div_dvd_in;
      div_dvs_ff      <= div_dvs_in;
      rsp_is_write_ff <= rsp_is_write_in;
      rsp_primary_ff  <= rsp_primary_in;
      rsp_mirror_ff   <= rsp_mirror_in;
      rsp_devoff_ff   <= rsp_devoff_in;
      rsp_len_ff      <= rsp_len_in;
      rsp_host_ff     <= rsp_host_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_is_write       = rsp_is_write_ff;
   assign rsp_primary_target = rsp_primary_ff;
   assign rsp_mirror_target  = rsp_mirror_ff;
   assign rsp_device_offset  = rsp_devoff_ff;
   assign rsp_command_length = rsp_len_ff;
   assign rsp_host_offset    = rsp_host_ff;
   assign rsp_last           = rsp_last_ff;

   // checks
   a_primary_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_primary_target} < n_ff))
      else $error("primary target beyond stripe count");

   a_mirror_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_mirror_target == CW'({1'b0, rsp_primary_target} + n_ff)))
      else $error("mirror target is not primary plus stripe count");

   a_zero_len_dropped: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_request_length == '0)) |=> !busy)
      else $error("zero length request started a pass");

   a_last_ends_pass: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("final command shown while sequencer still busy");

   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy)
      else $error("non-final command shown after the pass ended");

endmodule

/* bench/raid10_stripe_mirror_splitter_top_tb.sv */
`timescale 1ns / 1ps
// Testbench: RAID-10 splitter, predicted stripe commands checked across stripe count settings.
module raid10_stripe_mirror_splitter_top_tb;

   localparam int OFF_W    = r10s_pkg::OFF_W;
   localparam int LEN_W    = r10s_pkg::LEN_W;
   localparam int STRIPE_W = r10s_pkg::STRIPE_W;
   localparam int CNT_W    = r10s_pkg::CNT_W;

   // request kinds
   localparam bit CMD_READ  = 1'b0;
   localparam bit CMD_WRITE = 1'b1;

   localparam int unsigned BLK_BYTES     = r10s_pkg::DEF_BLOCK_BYTES;
   localparam int unsigned STRIPE_LIMIT  = r10s_pkg::DEF_MAX_STRIPES;
   localparam int unsigned DRAIN_LIMIT   = 20000;  // cycles to wait for outstanding commands
   localparam int unsigned SETTLE_CYCLES = 200;    // longer than one full pass
   localparam int unsigned PHASE_ITEMS   = 36;

   // One merged command for one stripe, as the block reports it.
   typedef struct {
      bit                is_write;
      bit [STRIPE_W-1:0] primary;
      bit [CNT_W-1:0]    mirror;
      bit [OFF_W-1:0]    dev_off;
      bit [LEN_W-1:0]    cmd_len;
      bit [LEN_W-1:0]    host_off;
      bit                last;
   } stripe_cmd_type;

   // Splits each request the way the block should, then matches the strobed commands in order.
   class splitter_scoreboard_type;
      stripe_cmd_type stripe_cmds[$];
      bit [CNT_W-1:0] stripe_reg;
      int unsigned    errors;
      int unsigned    checked;

      function new();
         stripe_reg = r10s_pkg::CSR_RESET;
         errors     = 0;
         checked    = 0;
      endfunction

      function void set_stripe_count(bit [CNT_W-1:0] value);
         stripe_reg = value;
      endfunction

      function int unsigned pending();
         return stripe_cmds.size();
      endfunction

      // zero reads as one pair, anything past the limit is clamped
      function longint unsigned live_stripes();
         if (stripe_reg == 0) return 1;
         if (stripe_reg > STRIPE_LIMIT) return STRIPE_LIMIT;
         return stripe_reg;
      endfunction

      function void note_request(bit cmd, bit [OFF_W-1:0] off, bit [LEN_W-1:0] len);
         longint unsigned blk = BLK_BYTES;
         longint unsigned sc, last_byte, b0, b1, r0, k, m, kl, total, first;
         stripe_cmd_type  item;
         stripe_cmd_type  batch[$];
         if (len == 0) return;
         sc        = live_stripes();
         last_byte = longint'(off) + longint'(len) - 1;  // may run past 40 bits
         b0        = longint'(off) / blk;
         b1        = last_byte / blk;
         r0        = b0 % sc;
         for (longint unsigned s = 0; s < sc; s++) begin
            k = b0 + ((s + sc - r0) % sc);  // first block of the request on stripe s
            if (k > b1) continue;
            m     = (b1 - k) / sc + 1;
            kl    = k + (m - 1) * sc;
            total = m * blk;
            first = k * blk;
            if (k == b0) begin
               total -= longint'(off) - b0 * blk;
               first  = longint'(off);
            end
            if (kl == b1) total -= (b1 + 1) * blk - 1 - last_byte;
            item.is_write = cmd;
            item.primary  = STRIPE_W'(s);
            item.mirror   = CNT_W'(s + sc);
            item.dev_off  = OFF_W'((k / sc) * blk + (first - k * blk));
            item.cmd_len  = LEN_W'(total);
            item.host_off = LEN_W'(first - longint'(off));
            item.last     = 1'b0;
            batch = {batch, item};
         end
         batch[batch.size() - 1].last = 1'b1;
         foreach (batch[i]) stripe_cmds = {stripe_cmds, batch[i]};
      endfunction

      function void compare_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(stripe_cmd_type got);
         stripe_cmd_type want;
         if (stripe_cmds.size() == 0) begin
            $error("stripe command with nothing outstanding (primary %0d)", got.primary);
            errors++;
            return;
         end
         want = stripe_cmds.pop_front();
         checked++;
         compare_field("is_write", want.is_write, got.is_write);
         compare_field("primary_target", want.primary, got.primary);
         compare_field("mirror_target", want.mirror, got.mirror);
         compare_field("device_offset", want.dev_off, got.dev_off);
         compare_field("command_length", want.cmd_len, got.cmd_len);
         compare_field("host_offset", want.host_off, got.host_off);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   // every input known from time zero; reset held high from the start
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en = 1'b0;
   logic [CNT_W-1:0]  csr_wr_data = '0;
   logic              start = 1'b0;
   logic              busy;
   logic              req_cmd = CMD_READ;
   logic [OFF_W-1:0]  req_request_offset = '0;
   logic [LEN_W-1:0]  req_request_length = '0;
   logic              rsp_valid;
   logic              rsp_is_write;
   logic [STRIPE_W-1:0] rsp_primary_target;
   logic [CNT_W-1:0]  rsp_mirror_target;
   logic [OFF_W-1:0]  rsp_device_offset;
   logic [LEN_W-1:0]  rsp_command_length;
   logic [LEN_W-1:0]  rsp_host_offset;
   logic              rsp_last;

   splitter_scoreboard_type sb = new();
   int unsigned        requests_sent = 0;
   int unsigned        settings_used = 1;  // reset value counts as the first

   raid10_stripe_mirror_splitter_top dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_request_offset (req_request_offset),
      .req_request_length (req_request_length),
      .rsp_valid          (rsp_valid),
      .rsp_is_write       (rsp_is_write),
      .rsp_primary_target (rsp_primary_target),
      .rsp_mirror_target  (rsp_mirror_target),
      .rsp_device_offset  (rsp_device_offset),
      .rsp_command_length (rsp_command_length),
      .rsp_host_offset    (rsp_host_offset),
      .rsp_last           (rsp_last)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Strobes last one cycle and cannot be stalled: sample every edge.
   // Values read here are the ones from before the edge.
   always @(posedge clock) begin : rsp_monitor
      stripe_cmd_type got;
      if (!reset && rsp_valid) begin
         got.is_write = rsp_is_write;
         got.primary  = rsp_primary_target;
         got.mirror   = rsp_mirror_target;
         got.dev_off  = rsp_device_offset;
         got.cmd_len  = rsp_command_length;
         got.host_off = rsp_host_offset;
         got.last     = rsp_last;
         sb.check_result(got);
      end
   end

   // Entered right after a rising edge. Start stays high on return so that a
   // back-to-back request does not lower and raise it in one step; the caller
   // lowers it before any gap.
   task automatic send_request(bit cmd, bit [OFF_W-1:0] off, bit [LEN_W-1:0] len);
      start              <= 1'b1;
      req_cmd            <= cmd;
      req_request_offset <= off;
      req_request_length <= len;
      @(posedge clock);
      while (busy) @(posedge clock);
      // accepted at this edge
      sb.note_request(cmd, off, len);
      requests_sent++;
   endtask

   // Only called with the block idle and nothing outstanding.
   task automatic write_stripe_count(bit [CNT_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_stripe_count(value);
      settings_used++;
   endtask

   // Wait for every predicted command, then a full pass worth of quiet cycles:
   // a zero length request can leave nothing outstanding while the block still settles.
   task automatic drain();
      int unsigned waited = 0;
      while ((sb.pending() != 0 || busy) && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (waited >= DRAIN_LIMIT) begin
         $error("block did not go idle, %0d commands outstanding", sb.pending());
         sb.errors++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mix of offset and length shapes: block aligned, straddling block edges,
   // near the top of the 40-bit space, a few zero lengths and a few very long ones.
   task automatic pick_request(output bit cmd, output bit [OFF_W-1:0] off,
                               output bit [LEN_W-1:0] len);
      bit [OFF_W-1:0] wide;
      int unsigned    pick;
      wide = OFF_W'({$urandom, $urandom});
      cmd  = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
      pick = $urandom_range(0, 99);
      if (pick < 40)      off = OFF_W'($urandom_range(0, 32'h00FF_FFFF));
      else if (pick < 60) off = wide;
      else if (pick < 75) off = wide & ~OFF_W'(BLK_BYTES - 1);
      else if (pick < 85) off = {OFF_W{1'b1}} - OFF_W'($urandom_range(0, 200000));
      else                off = wide | OFF_W'(BLK_BYTES - 1);  // last byte of a block
      pick = $urandom_range(0, 99);
      if (pick < 5)       len = '0;
      else if (pick < 55) len = LEN_W'($urandom_range(1, 8 * BLK_BYTES));
      else if (pick < 80) len = LEN_W'($urandom_range(1, 100 * BLK_BYTES));
      else if (pick < 90) len = LEN_W'(BLK_BYTES * $urandom_range(1, 64));
      else if (pick < 96) len = LEN_W'($urandom_range(1, BLK_BYTES));
      else                len = LEN_W'($urandom_range(0, 24'hFF_FFFF));
   endtask

   // Bursts of back-to-back requests separated by random gaps, mostly short,
   // now and then long enough to let the block go fully idle.
   task automatic run_random(int unsigned count);
      int unsigned    burst_left;
      int unsigned    gap;
      bit             cmd;
      bit [OFF_W-1:0] off;
      bit [LEN_W-1:0] len;
      burst_left = $urandom_range(1, 8);
      for (int unsigned i = 0; i < count; i++) begin
         pick_request(cmd, off, len);
         send_request(cmd, off, len);
         burst_left--;
         if (burst_left == 0 && i + 1 < count) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 160) : $urandom_range(0, 12);
            if (gap != 0) begin
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = $urandom_range(1, 8);
         end
      end
      start <= 1'b0;
   endtask

   initial begin : stimulus
      bit [CNT_W-1:0] settings[$];
      settings = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd7, 6'd33, 6'd2, 6'd3};
      settings = {settings, CNT_W'($urandom_range(0, 63))};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests at the reset stripe count of 3.
      send_request(CMD_READ, '0, '0);                          // zero length: no commands
      send_request(CMD_WRITE, {OFF_W{1'b1}}, '0);              // zero length at the top
      send_request(CMD_READ, '0, 24'd1);                       // single byte
      send_request(CMD_WRITE, '0, LEN_W'(BLK_BYTES));          // one whole block
      send_request(CMD_READ, '0, LEN_W'(3 * BLK_BYTES));       // one block on every stripe
      send_request(CMD_WRITE, OFF_W'(BLK_BYTES - 1), 24'd2);   // straddles a block edge
      send_request(CMD_READ, 40'd100, LEN_W'(10 * BLK_BYTES)); // several blocks per stripe
      send_request(CMD_WRITE, OFF_W'(5 * BLK_BYTES + 7), LEN_W'(BLK_BYTES)); // starts on stripe 2
      send_request(CMD_READ, OFF_W'(4 * BLK_BYTES), LEN_W'(2 * BLK_BYTES - 1));
      send_request(CMD_WRITE, '0, {LEN_W{1'b1}});              // longest request
      send_request(CMD_READ, {OFF_W{1'b1}}, 24'd1);            // very last byte
      send_request(CMD_WRITE, {OFF_W{1'b1}}, {LEN_W{1'b1}});   // end past the 40-bit space
      send_request(CMD_READ, 40'hFF_FFFF_F000, LEN_W'(2 * BLK_BYTES));  // wraps the top
      send_request(CMD_WRITE, 40'h55_5555_5555, 24'hAA_AAAA);
      send_request(CMD_READ, 40'hAA_AAAA_AAAA, 24'h55_5555);
      start <= 1'b0;
      drain();

      run_random(PHASE_ITEMS);
      drain();
      // Each later phase: new stripe count, including zero, the maximum and
      // values past it, then random traffic.
      foreach (settings[i]) begin
         write_stripe_count(settings[i]);
         run_random(PHASE_ITEMS);
         drain();
      end

      if (sb.pending() != 0) begin
         $error("%0d stripe commands never arrived", sb.pending());
         sb.errors++;
      end
      $display("Covered %0d requests over %0d stripe count settings, %0d stripe commands compared.",
               requests_sent, settings_used, sb.checked);
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Hard stop, several times the slowest legal run.
   initial begin : watchdog
      #7_200_000;
      $display("simulation failed");
      $finish;
   end

endmodule
